@@ src/vbe_pkg.sv @@
package vbe_pkg;

    localparam int DATA_W   = 32;
    localparam int DT_W     = 20;
    localparam int ALPHA_W  = 16;
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W    = 5;
    localparam int SAT_W    = 52;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64880;
    localparam logic [DT_W-1:0]    DT_MIN_US   = 20'd1;
    localparam logic [DT_W-1:0]    DT_MAX_US   = 20'd1000000;
    localparam logic [DT_W-1:0]    US_PER_S    = 20'd1000000;
    localparam logic [ALPHA_W:0]   ONE_Q16     = 17'd65536;
    localparam logic [DATA_W-1:0]  INT32_MAX   = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0]  INT32_MIN   = 32'h8000_0000;

    // warm-up codes
    localparam logic [1:0] WARM_NONE   = 2'd0;
    localparam logic [1:0] WARM_ONE    = 2'd1;
    localparam logic [1:0] WARM_ACTIVE = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_ALPHA = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POS_SUB,
        ST_POS_MUL,
        ST_POS_LOAD,
        ST_POS_DIV,
        ST_POS_WRITE,
        ST_POS_COMMIT,
        ST_VEL_DECIDE,
        ST_VEL_MUL_A,
        ST_VEL_MUL_B,
        ST_VEL_SUM,
        ST_VEL_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              load_input;
        logic              pos_sub;
        logic              pos_mul;
        logic              pos_load;
        logic              div_step;
        logic              pos_write;
        logic              pos_commit;
        logic              vel_mul_a;
        logic              vel_mul_b;
        logic              vel_sum;
        logic              vel_write;
        logic              emit;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic       pos_present;
        logic       vel_present;
        logic [1:0] warm;
        logic       out_free;
    } sts_t;

    // saturate a sign-extended value to 32 bits
    function automatic logic [DATA_W-1:0] sat32(input logic [SAT_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1))
        begin
            r = v[DATA_W-1:0];
        end
        else
        begin
            r = v[SAT_W-1] ? INT32_MIN : INT32_MAX;
        end
        return r;
    endfunction

endpackage

@@ src/velocity_bias_estimator_unit.sv @@
// velocity bias estimator
// input stream s_*: one item per update, carrying position and/or velocity with dt
// output stream m_*: one result per accepted item, bias-corrected velocity
// apb port: register 0 at byte address 0 is the bias retention factor alpha (q0.16)
// an item is taken only while the unit is idle; the result sits in an output register,
// so the next item is taken while a finished result still waits for m_tready
// processing per item:
//   item without position: straight to the bias step; a first position is only stored
//   item with position after warm-up: derived velocity per axis through one shared
//   radix-2 divider, then the bias update per axis when a velocity is present and
//   warm-up is done; the next item is taken only once its result is written out
// reset clears positions, derived velocities, bias and warm-up state; alpha
// returns to its reset value; no result is pending after reset
// a stalled receiver holds the result in place; a further finished result waits in
// the emit state, and no further item is taken until it is written
module velocity_bias_estimator_unit (
    input  logic          clk,
    input  logic          rst_n,
    // apb configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // pos_x, pos_y, pos_z, vel_in_x, vel_in_y, vel_in_z, interval_us, 4 zero bits
    input  logic [215:0]  s_tdata,
    // position_present, velocity_present
    input  logic [1:0]    s_tuser,
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // vel_out_x, vel_out_y, vel_out_z
    output logic [95:0]   m_tdata,
    // bias_active
    output logic          m_tuser
);

    logic [vbe_pkg::ALPHA_W-1:0] alpha_reg;
    logic                        cfg_write;
    vbe_pkg::cmd_t               cmd;
    vbe_pkg::sts_t               sts;

    // apb: pready always high, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == vbe_pkg::REG_ALPHA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= vbe_pkg::ALPHA_RESET;
        else if (cfg_write)
            alpha_reg <= pwdata[vbe_pkg::ALPHA_W-1:0];
    end

    // reads beyond the register list return zero
    assign prdata = (paddr[2] == vbe_pkg::REG_ALPHA) ? {16'b0, alpha_reg} : 32'b0;

    // sequencer: walks axes through the divider and bias filter
    vbe_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, filter state and output register
    vbe_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .alpha    (alpha_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/vbe_controller.sv @@
module vbe_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  vbe_pkg::sts_t sts,
    output vbe_pkg::cmd_t cmd
);

    localparam logic [vbe_pkg::CNT_W-1:0]  CNT_LAST  = vbe_pkg::CNT_W'(vbe_pkg::DIV_STEPS - 1);
    localparam logic [vbe_pkg::AXIS_W-1:0] AXIS_LAST = vbe_pkg::AXIS_W'(vbe_pkg::AXES - 1);

    vbe_pkg::state_t              state_reg, state_next;
    logic [vbe_pkg::AXIS_W-1:0]   axis_reg, axis_next;
    logic [vbe_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vbe_pkg::ST_IDLE;
            axis_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            vbe_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_input = 1'b1;
                    state_next     = vbe_pkg::ST_DECIDE;
                end
            end
            vbe_pkg::ST_DECIDE:
            begin
                axis_next = '0;
                if (!sts.pos_present)
                    state_next = vbe_pkg::ST_VEL_DECIDE;
                else if (sts.warm == vbe_pkg::WARM_NONE)
                    state_next = vbe_pkg::ST_POS_COMMIT;
                else
                    state_next = vbe_pkg::ST_POS_SUB;
            end
            vbe_pkg::ST_POS_SUB:
            begin
                cmd.pos_sub = 1'b1;
                state_next  = vbe_pkg::ST_POS_MUL;
            end
            vbe_pkg::ST_POS_MUL:
            begin
                cmd.pos_mul = 1'b1;
                state_next  = vbe_pkg::ST_POS_LOAD;
            end
            vbe_pkg::ST_POS_LOAD:
            begin
                cmd.pos_load = 1'b1;
                cnt_next     = '0;
                state_next   = vbe_pkg::ST_POS_DIV;
            end
            vbe_pkg::ST_POS_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = vbe_pkg::ST_POS_WRITE;
            end
            vbe_pkg::ST_POS_WRITE:
            begin
                cmd.pos_write = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = vbe_pkg::ST_POS_COMMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = vbe_pkg::ST_POS_SUB;
                end
            end
            vbe_pkg::ST_POS_COMMIT:
            begin
                cmd.pos_commit = 1'b1;
                state_next     = vbe_pkg::ST_VEL_DECIDE;
            end
            vbe_pkg::ST_VEL_DECIDE:
            begin
                axis_next = '0;
                if (sts.vel_present && (sts.warm == vbe_pkg::WARM_ACTIVE))
                    state_next = vbe_pkg::ST_VEL_MUL_A;
                else
                    state_next = vbe_pkg::ST_EMIT;
            end
            vbe_pkg::ST_VEL_MUL_A:
            begin
                cmd.vel_mul_a = 1'b1;
                state_next    = vbe_pkg::ST_VEL_MUL_B;
            end
            vbe_pkg::ST_VEL_MUL_B:
            begin
                cmd.vel_mul_b = 1'b1;
                state_next    = vbe_pkg::ST_VEL_SUM;
            end
            vbe_pkg::ST_VEL_SUM:
            begin
                cmd.vel_sum = 1'b1;
                state_next  = vbe_pkg::ST_VEL_WRITE;
            end
            vbe_pkg::ST_VEL_WRITE:
            begin
                cmd.vel_write = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = vbe_pkg::ST_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = vbe_pkg::ST_VEL_MUL_A;
                end
            end
            vbe_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = vbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vbe_pkg::ST_IDLE;
            end
        endcase
    end

    // result only written into a free output register
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("result written over a pending output");

    // divider runs exactly its step count before the quotient is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && (cnt_reg == CNT_LAST)) |=> (state_reg == vbe_pkg::ST_POS_WRITE))
        else $error("divider step count broken");

    // a position commit always leaves at least one position seen
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_commit |=> (sts.warm != vbe_pkg::WARM_NONE))
        else $error("warm-up not advanced by position update");

    // bias is only filtered once a derived velocity exists
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vel_mul_a |-> (sts.warm == vbe_pkg::WARM_ACTIVE))
        else $error("bias update before derived velocity");

endmodule

@@ src/vbe_datapath.sv @@
module vbe_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vbe_pkg::cmd_t                 cmd,
    output vbe_pkg::sts_t                 sts,
    input  logic [vbe_pkg::ALPHA_W-1:0]   alpha,
    input  logic [215:0]                  s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,
    output logic                          m_tuser
);

    localparam int W = vbe_pkg::DATA_W;

    // latched item
    logic                          pos_present_reg, vel_present_reg;
    logic [W-1:0]                  pos_reg [vbe_pkg::AXES];
    logic [W-1:0]                  vin_reg [vbe_pkg::AXES];
    logic [vbe_pkg::DT_W-1:0]      dt_reg;

    // filter state
    logic [W-1:0]                  prev_pos_reg [vbe_pkg::AXES];
    logic [W-1:0]                  derived_reg  [vbe_pkg::AXES];
    logic [W-1:0]                  bias_reg     [vbe_pkg::AXES];
    logic [1:0]                    warm_reg;

    // working registers
    logic                          neg_reg;
    logic [W:0]                    mag_reg;
    logic [52:0]                   num_reg;
    logic                          ovf_reg;
    logic [vbe_pkg::DT_W-1:0]      rem_reg;
    logic [W-1:0]                  quo_reg;
    logic signed [48:0]            prod_a_reg;
    logic signed [50:0]            prod_b_reg;
    logic signed [51:0]            acc_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [W-1:0]                  vout_reg [vbe_pkg::AXES];
    logic                          bias_active_reg;

    logic [vbe_pkg::DT_W-1:0]      dt_in, dt_clamped;
    logic [W-1:0]                  pos_sel, prev_sel, vin_sel, derived_sel, bias_sel;
    logic signed [W:0]             delta;
    logic [W:0]                    delta_abs;
    logic [52:0]                   num_next;
    logic [20:0]                   num_hi;
    logic [20:0]                   trial;
    logic                          trial_ge;
    logic [W-1:0]                  derived_next;
    logic [vbe_pkg::ALPHA_W:0]     beta;
    logic signed [W:0]             diff;
    logic signed [48:0]            prod_a_next;
    logic signed [50:0]            prod_b_next;
    logic signed [51:0]            acc_next;
    logic signed [51:0]            acc_rnd;
    logic [W-1:0]                  bias_next;
    logic [W-1:0]                  vout_next [vbe_pkg::AXES];

    always_comb
    begin
        dt_in = s_tdata[211:192];
        if (dt_in < vbe_pkg::DT_MIN_US)
            dt_clamped = vbe_pkg::DT_MIN_US;
        else if (dt_in > vbe_pkg::DT_MAX_US)
            dt_clamped = vbe_pkg::DT_MAX_US;
        else
            dt_clamped = dt_in;
    end

    assign pos_sel     = pos_reg[cmd.axis];
    assign prev_sel    = prev_pos_reg[cmd.axis];
    assign vin_sel     = vin_reg[cmd.axis];
    assign derived_sel = derived_reg[cmd.axis];
    assign bias_sel    = bias_reg[cmd.axis];

    // derived velocity: |delta| * 1e6 + dt/2, then restoring divide by dt
    assign delta     = $signed({pos_sel[W-1], pos_sel}) - $signed({prev_sel[W-1], prev_sel});
    assign delta_abs = delta[W] ? (W+1)'(-delta) : (W+1)'(delta);
    assign num_next  = ({20'b0, mag_reg} * {33'b0, vbe_pkg::US_PER_S})
                     + {34'b0, dt_reg[vbe_pkg::DT_W-1:1]};
    assign num_hi    = num_reg[52:32];
    assign trial     = {rem_reg, quo_reg[W-1]};
    assign trial_ge  = trial >= {1'b0, dt_reg};

    always_comb
    begin
        if (ovf_reg)
            derived_next = neg_reg ? vbe_pkg::INT32_MIN : vbe_pkg::INT32_MAX;
        else if (!neg_reg)
            derived_next = quo_reg[W-1] ? vbe_pkg::INT32_MAX : quo_reg;
        else if (quo_reg[W-1] && (|quo_reg[W-2:0]))
            derived_next = vbe_pkg::INT32_MIN;
        else
            derived_next = W'(32'd0 - quo_reg);
    end

    // bias filter: alpha * bias + (1 - alpha) * (derived - vin), rounded
    assign beta        = vbe_pkg::ONE_Q16 - {1'b0, alpha};
    assign diff        = $signed({derived_sel[W-1], derived_sel}) - $signed({vin_sel[W-1], vin_sel});
    assign prod_a_next = $signed({1'b0, alpha}) * $signed(bias_sel);
    assign prod_b_next = $signed({1'b0, beta}) * diff;
    assign acc_next    = prod_a_reg + prod_b_reg;
    // ties away from zero: negative values round with one less
    assign acc_rnd     = acc_reg + (acc_reg[51] ? 52'sd32767 : 52'sd32768);
    assign bias_next   = vbe_pkg::sat32({{16{acc_rnd[51]}}, acc_rnd[51:16]});

    always_comb
    begin
        for (int i = 0; i < vbe_pkg::AXES; i++)
        begin
            logic [W:0] s;
            s = {vin_reg[i][W-1], vin_reg[i]} + {bias_reg[i][W-1], bias_reg[i]};
            if (vel_present_reg)
                vout_next[i] = vbe_pkg::sat32({{19{s[W]}}, s});
            else
                vout_next[i] = vin_reg[i];
        end
    end

    // item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            pos_present_reg <= s_tuser[0];
            vel_present_reg <= s_tuser[1];
            for (int i = 0; i < vbe_pkg::AXES; i++)
            begin
                pos_reg[i] <= s_tdata[i*W +: W];
                vin_reg[i] <= s_tdata[(i+3)*W +: W];
            end
            dt_reg <= dt_clamped;
        end
        if (cmd.pos_sub)
        begin
            neg_reg <= delta[W];
            mag_reg <= delta_abs;
        end
        if (cmd.pos_mul)
            num_reg <= num_next;
        if (cmd.pos_load)
        begin
            ovf_reg <= num_hi >= {1'b0, dt_reg};
            rem_reg <= num_reg[51:32];
            quo_reg <= num_reg[31:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? vbe_pkg::DT_W'(trial - {1'b0, dt_reg}) : trial[19:0];
            quo_reg <= {quo_reg[W-2:0], trial_ge};
        end
        if (cmd.vel_mul_a)
            prod_a_reg <= prod_a_next;
        if (cmd.vel_mul_b)
            prod_b_reg <= prod_b_next;
        if (cmd.vel_sum)
            acc_reg <= acc_next;
        if (cmd.emit)
        begin
            for (int i = 0; i < vbe_pkg::AXES; i++)
                vout_reg[i] <= vout_next[i];
            bias_active_reg <= warm_reg == vbe_pkg::WARM_ACTIVE;
        end
    end

    // filter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vbe_pkg::AXES; i++)
            begin
                prev_pos_reg[i] <= '0;
                derived_reg[i]  <= '0;
                bias_reg[i]     <= '0;
            end
            warm_reg <= vbe_pkg::WARM_NONE;
        end
        else
        begin
            if (cmd.pos_write)
                derived_reg[cmd.axis] <= derived_next;
            if (cmd.pos_commit)
            begin
                for (int i = 0; i < vbe_pkg::AXES; i++)
                    prev_pos_reg[i] <= pos_reg[i];
                warm_reg <= (warm_reg == vbe_pkg::WARM_NONE) ? vbe_pkg::WARM_ONE
                                                             : vbe_pkg::WARM_ACTIVE;
            end
            if (cmd.vel_write)
                bias_reg[cmd.axis] <= bias_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign sts.pos_present = pos_present_reg;
    assign sts.vel_present = vel_present_reg;
    assign sts.warm        = warm_reg;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {vout_reg[2], vout_reg[1], vout_reg[0]};
    assign m_tuser  = bias_active_reg;

endmodule
